FILE: design/utf8v_pkg.sv
`timescale 1ns / 1ps
// utf8v_pkg: types, constants and helper functions for the utf-8 stream validator
// no dependencies; used by every module of the block

package utf8v_pkg;

   // width of the internal byte offset counters
   localparam int OFFSET_BITS = 32;
   localparam int CODE_BITS   = 21;
   localparam int RSP_OFFSET_BITS = 32;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   // lead byte ranges
   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   // sequence widths
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_TWO  = 3'd2;
   localparam logic [2:0] SEQ_THREE = 3'd3;
   localparam logic [2:0] SEQ_FOUR = 3'd4;

   // code point limits
   localparam logic [CODE_BITS-1:0] MIN_TWO      = 21'h00080;
   localparam logic [CODE_BITS-1:0] MIN_THREE    = 21'h00800;
   localparam logic [CODE_BITS-1:0] MIN_FOUR     = 21'h10000;
   localparam logic [CODE_BITS-1:0] CODE_MAX     = 21'h10FFFF;
   localparam logic [CODE_BITS-1:0] SURR_LO      = 21'h0D800;
   localparam logic [CODE_BITS-1:0] SURR_HI      = 21'h0DFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                       well_formed;
      logic [RSP_OFFSET_BITS-1:0] error_offset;
   } rsp_type;

   // clamp an internal offset to the reported offset width
   function automatic logic [RSP_OFFSET_BITS-1:0] clamp_offset(
      input logic [OFFSET_BITS-1:0] off
   );
      logic [63:0] wide;
      wide = 64'(off);
      if (wide > 64'(32'hFFFF_FFFF)) begin
         return {RSP_OFFSET_BITS{1'b1}};
      end
      return wide[RSP_OFFSET_BITS-1:0];
   endfunction

   // smallest legal value for a sequence of the given width
   function automatic logic [CODE_BITS-1:0] seq_minimum(input logic [2:0] width);
      case (width)
         SEQ_TWO:   return MIN_TWO;
         SEQ_THREE: return MIN_THREE;
         default:   return MIN_FOUR;
      endcase
   endfunction

endpackage

FILE: design/utf8_stream_validator.sv
`timescale 1ns / 1ps
// utf8_stream_validator: strict utf-8 check of a byte stream, top level
// depends on utf8v_pkg and utf8v_tracker
//
// usage
//   req channel: one word per byte of text (has_byte = 1), or an empty word
//   (has_byte = 0) that only closes the stream when last = 1
//   rsp channel: one word per stream, produced for the req word marked last;
//   well_formed = 1 with error_offset = 0, or well_formed = 0 with the byte
//   offset of the first error (saturating)
// verdict path: the last word is taken into the input register, then its
//   verdict is decoded into the output register once that register is free,
//   and rsp_valid rises from the output register
// throughput: one req word per cycle while req_stall is low, set by the single
//   decode step between the input register and the sequence state registers
// stall: while rsp_stall holds a verdict, non-last words keep flowing; a
//   second last word waits in the input register and req_stall goes high
//   until the output register frees up
// reset: synchronous, clears the valid bits of both pipeline registers and
//   all sequence state; after a verdict the state also returns to reset

module utf8_stream_validator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utf8v_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8v_pkg::rsp_type rsp_data
);

   // input register
   logic               in_valid_ff, in_valid_in;
   utf8v_pkg::req_type in_data_ff, in_data_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   utf8v_pkg::rsp_type out_data_ff, out_data_in;

   logic               out_free;
   logic               advance;
   utf8v_pkg::rsp_type verdict;

   // output register can take a new verdict when empty or being drained
   assign out_free = !out_valid_ff || !rsp_stall;
   // only a last word needs room downstream
   assign advance  = in_valid_ff && (!in_data_ff.last || out_free);
   assign req_stall = in_valid_ff && !advance;

   utf8v_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .verdict (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && in_data_ff.last) begin
         out_valid_in = 1'b1;
         out_data_in  = verdict;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: design/utf8v_tracker.sv
`timescale 1ns / 1ps
// utf8v_tracker: sequence state registers and per-word decode for the validator
// depends on utf8v_pkg

module utf8v_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  utf8v_pkg::req_type item,
   output utf8v_pkg::rsp_type verdict
);

   logic [utf8v_pkg::OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [utf8v_pkg::OFFSET_BITS-1:0] start_ff, start_in;
   logic [2:0]                        width_ff, width_in;
   logic [2:0]                        count_ff, count_in;
   logic [utf8v_pkg::CODE_BITS-1:0]   code_ff, code_in;
   logic                              pend_ff, pend_in;
   logic [utf8v_pkg::OFFSET_BITS-1:0] pend_off_ff, pend_off_in;
   logic                              err_ff, err_in;
   logic [utf8v_pkg::OFFSET_BITS-1:0] err_off_ff, err_off_in;

   logic [7:0] b;
   logic       bad_code;

   assign b = item.data_byte;

   always_comb begin
      pos_in      = pos_ff;
      start_in    = start_ff;
      width_in    = width_ff;
      count_in    = count_ff;
      code_in     = code_ff;
      pend_in     = pend_ff;
      pend_off_in = pend_off_ff;
      err_in      = err_ff;
      err_off_in  = err_off_ff;
      bad_code    = 1'b0;

      if (item.has_byte && !err_ff) begin
         if (width_ff == utf8v_pkg::SEQ_NONE) begin
            if (b >= utf8v_pkg::ASCII_LIMIT) begin
               if (b inside {[utf8v_pkg::LEAD2_LO : utf8v_pkg::LEAD2_HI]}) begin
                  width_in = utf8v_pkg::SEQ_TWO;
                  code_in  = utf8v_pkg::CODE_BITS'(b[4:0]);
               end else if (b inside {[utf8v_pkg::LEAD3_LO : utf8v_pkg::LEAD3_HI]}) begin
                  width_in = utf8v_pkg::SEQ_THREE;
                  code_in  = utf8v_pkg::CODE_BITS'(b[3:0]);
               end else if (b inside {[utf8v_pkg::LEAD4_LO : utf8v_pkg::LEAD4_HI]}) begin
                  width_in = utf8v_pkg::SEQ_FOUR;
                  code_in  = utf8v_pkg::CODE_BITS'(b[2:0]);
               end else begin
                  err_in     = 1'b1;
                  err_off_in = pos_ff;
               end
               if (!err_in) begin
                  count_in    = 3'd1;
                  start_in    = pos_ff;
                  pend_in     = 1'b0;
                  pend_off_in = '0;
               end
            end
         end else begin
            count_in = count_ff + 3'd1;
            if (!pend_ff) begin
               if (b[7:6] != 2'b10) begin
                  pend_in     = 1'b1;
                  pend_off_in = pos_ff;
               end else begin
                  code_in = {code_ff[utf8v_pkg::CODE_BITS-7:0], b[5:0]};
               end
            end
            // sequence complete: judge it
            if (count_in >= width_ff) begin
               bad_code = (code_in < utf8v_pkg::seq_minimum(width_ff)) ||
                          (code_in > utf8v_pkg::CODE_MAX) ||
                          ((code_in >= utf8v_pkg::SURR_LO) && (code_in <= utf8v_pkg::SURR_HI));
               if (pend_in) begin
                  err_in     = 1'b1;
                  err_off_in = pend_off_in;
               end else if (bad_code) begin
                  err_in     = 1'b1;
                  err_off_in = start_ff;
               end
               width_in    = utf8v_pkg::SEQ_NONE;
               count_in    = 3'd0;
               code_in     = '0;
               pend_in     = 1'b0;
               pend_off_in = '0;
            end
         end
         if (pos_ff != utf8v_pkg::OFFSET_MAX) begin
            pos_in = pos_ff + {{(utf8v_pkg::OFFSET_BITS-1){1'b0}}, 1'b1};
         end
      end

      // truncated sequence at end of stream
      if (item.last && !err_in && (width_in != utf8v_pkg::SEQ_NONE)) begin
         err_in     = 1'b1;
         err_off_in = start_in;
      end

      verdict.well_formed  = !err_in;
      verdict.error_offset = err_in ? utf8v_pkg::clamp_offset(err_off_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last)) begin
         pos_ff      <= '0;
         start_ff    <= '0;
         width_ff    <= utf8v_pkg::SEQ_NONE;
         count_ff    <= '0;
         code_ff     <= '0;
         pend_ff     <= 1'b0;
         pend_off_ff <= '0;
         err_ff      <= 1'b0;
         err_off_ff  <= '0;
      end else if (step_en) begin
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         width_ff    <= width_in;
         count_ff    <= count_in;
         code_ff     <= code_in;
         pend_ff     <= pend_in;
         pend_off_ff <= pend_off_in;
         err_ff      <= err_in;
         err_off_ff  <= err_off_in;
      end
   end

endmodule

FILE: design/utf8v_checker.sv
`timescale 1ns / 1ps
// utf8v_checker: port-level assertions for the validator, bound to the top level
// depends on utf8v_pkg and utf8_stream_validator

module utf8v_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input utf8v_pkg::rsp_type rsp_data
);

   // a held verdict stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // a good verdict carries no offset
   assert property (@(posedge clock)
      rsp_valid && rsp_data.well_formed |-> rsp_data.error_offset == '0)
      else $error("well formed verdict with nonzero offset");

   // input only backs up behind a stalled verdict
   assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without downstream backpressure");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (.*);

FILE: tb/sv/tb_utf8_stream_validator.sv
`timescale 1ns / 1ps
// tb_utf8_stream_validator: self-checking bench for the utf-8 stream validator
// depends on utf8v_pkg and utf8_stream_validator; byte streams, random idling

module tb_utf8_stream_validator;

   import utf8v_pkg::*;

   // continuation bytes look like 10xxxxxx
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   // cycles with no accepted word before the run is declared hung
   localparam int IDLE_LIMIT = 400;
   // rough number of random words (empty words without last not counted)
   localparam int RANDOM_WORDS = 650;
   // margin waited after the last verdict has been checked
   localparam int DRAIN_CYCLES = 8;

   // predicts one verdict per stream and holds it until the block reports it
   class utf8_verdict_model;
      logic [31:0] next_offset;    // offset of the next byte, saturating
      logic [31:0] lead_offset;    // lead byte of the open sequence
      logic [31:0] bad_offset;     // first non-continuation inside the sequence
      logic [31:0] first_offset;   // offset of the first error of the stream
      logic [2:0]  seq_len;
      logic [2:0]  seq_seen;
      logic [20:0] code_acc;
      bit          bad_pending;
      bit          err_seen;
      rsp_type     verdicts_due[$];
      int          failures;

      function new();
         failures = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         next_offset  = '0;
         lead_offset  = '0;
         bad_offset   = '0;
         first_offset = '0;
         seq_len      = SEQ_NONE;
         seq_seen     = '0;
         code_acc     = '0;
         bad_pending  = 1'b0;
         err_seen     = 1'b0;
      endfunction

      function void mark_error(logic [31:0] where);
         if (!err_seen) begin
            err_seen     = 1'b1;
            first_offset = where;
         end
      endfunction

      function void absorb_byte(logic [7:0] b, logic [31:0] pos);
         logic [20:0] floor;
         if (seq_len == SEQ_NONE) begin
            if (b < ASCII_LIMIT) return;
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
               seq_len  = SEQ_TWO;
               code_acc = 21'(b[4:0]);
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
               seq_len  = SEQ_THREE;
               code_acc = 21'(b[3:0]);
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
               seq_len  = SEQ_FOUR;
               code_acc = 21'(b[2:0]);
            end else begin
               mark_error(pos);
               return;
            end
            seq_seen    = 3'd1;
            lead_offset = pos;
            bad_pending = 1'b0;
            bad_offset  = '0;
            return;
         end
         seq_seen = seq_seen + 3'd1;
         // once a bad byte is pending the rest of the sequence is only counted
         if (!bad_pending) begin
            if ((b & CONT_MASK) != CONT_TAG) begin
               bad_pending = 1'b1;
               bad_offset  = pos;
            end else begin
               code_acc = {code_acc[14:0], b[5:0]};
            end
         end
         if (seq_seen >= seq_len) begin
            case (seq_len)
               SEQ_TWO:   floor = MIN_TWO;
               SEQ_THREE: floor = MIN_THREE;
               default:   floor = MIN_FOUR;
            endcase
            if (bad_pending) begin
               mark_error(bad_offset);
            end else if (code_acc < floor || code_acc > CODE_MAX ||
                         (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
               mark_error(lead_offset);
            end
            seq_len     = SEQ_NONE;
            seq_seen    = '0;
            code_acc    = '0;
            bad_pending = 1'b0;
            bad_offset  = '0;
         end
      endfunction

      // an accepted request word
      function void note_word(req_type w);
         rsp_type verdict;
         if (w.has_byte && !err_seen) begin
            absorb_byte(w.data_byte, next_offset);
            if (next_offset != OFFSET_MAX) next_offset = next_offset + 32'd1;
         end
         if (w.last) begin
            // stream cut inside a sequence blames the lead byte
            if (!err_seen && seq_len != SEQ_NONE) mark_error(lead_offset);
            verdict.well_formed  = !err_seen;
            verdict.error_offset = err_seen ? first_offset : '0;
            verdicts_due = {verdicts_due, verdict};
            clear_stream();
         end
      endfunction

      // an accepted response word
      function void check_verdict(rsp_type got);
         rsp_type want;
         if (verdicts_due.size() == 0) begin
            $error("verdict with none pending: well_formed %0d error_offset %0h",
                   got.well_formed, got.error_offset);
            failures++;
            return;
         end
         want = verdicts_due.pop_front();
         if (got.well_formed !== want.well_formed) begin
            $error("well_formed: expected %0d, got %0d", want.well_formed, got.well_formed);
            failures++;
         end
         if (got.error_offset !== want.error_offset) begin
            $error("error_offset: expected %0h, got %0h",
                   want.error_offset, got.error_offset);
            failures++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   utf8_verdict_model verdict_model = new();
   req_type stream_q[$];     // words of the stream being built
   bit      req_quiet;       // no gaps between request words
   bit      rsp_quiet;       // no stalls on the response side
   int      sent_words;
   int      quiet_cycles;

   utf8_stream_validator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // both handshakes are seen here at the rising edge; the response is
   // checked before the request is noted so a same-cycle verdict never
   // matches the word that arrives with it
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         verdict_model.check_verdict(rsp_data);
      end
      if (!reset && req_valid && !req_stall) begin
         verdict_model.note_word(req_data);
      end
   end

   // watchdog: any accepted word on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: draw a stall length per verdict, then hold stall low
   // until that verdict is taken
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = rsp_quiet ? 0 : $urandom_range(0, 17);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // ---- stream building ----

   function automatic void push_word(logic [7:0] b, logic has);
      req_type w;
      w.data_byte = b;
      w.has_byte  = has;
      w.last      = 1'b0;
      stream_q = {stream_q, w};
   endfunction

   // empty words carry junk in the data field
   function automatic void push_empty();
      push_word(8'($urandom), 1'b0);
   endfunction

   // raw encoding of any value at the given width, legal or not
   function automatic void push_point(logic [20:0] cp, logic [2:0] width);
      case (width)
         SEQ_TWO: begin
            push_word({3'b110, cp[10:6]}, 1'b1);
         end
         SEQ_THREE: begin
            push_word({4'b1110, cp[15:12]}, 1'b1);
            push_word({2'b10, cp[11:6]}, 1'b1);
         end
         default: begin
            push_word({5'b11110, cp[20:18]}, 1'b1);
            push_word({2'b10, cp[17:12]}, 1'b1);
            push_word({2'b10, cp[11:6]}, 1'b1);
         end
      endcase
      push_word({2'b10, cp[5:0]}, 1'b1);
   endfunction

   // one well-formed character of random width
   function automatic void push_clean();
      logic [20:0] cp;
      case ($urandom_range(0, 3))
         0: push_word(8'($urandom_range(0, 8'h7F)), 1'b1);
         1: push_point(21'($urandom_range(32'h80, 32'h7FF)), SEQ_TWO);
         2: begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h4000;
            push_point(cp, SEQ_THREE);
         end
         default: push_point(21'($urandom_range(32'h10000, 32'h10FFFF)), SEQ_FOUR);
      endcase
   endfunction

   // one broken character
   function automatic void push_fault();
      int       start;
      int       pick;
      logic [2:0] width;
      width = ($urandom_range(0, 1) == 0) ? SEQ_THREE : SEQ_FOUR;
      case ($urandom_range(0, 6))
         // stray continuation or c0/c1 lead
         0: push_word(8'($urandom_range(8'h80, 8'hC1)), 1'b1);
         // lead above f4
         1: push_word(8'($urandom_range(8'hF5, 8'hFF)), 1'b1);
         // overlong
         2: begin
            if (width == SEQ_THREE) push_point(21'($urandom_range(0, 32'h7FF)), SEQ_THREE);
            else push_point(21'($urandom_range(0, 32'hFFFF)), SEQ_FOUR);
         end
         // surrogate
         3: push_point(21'($urandom_range(32'hD800, 32'hDFFF)), SEQ_THREE);
         // beyond 10ffff with an f4 lead
         4: push_point(21'($urandom_range(32'h110000, 32'h13FFFF)), SEQ_FOUR);
         // non-continuation byte somewhere after the lead
         5: begin
            if ($urandom_range(0, 2) == 0) width = SEQ_TWO;
            start = stream_q.size();
            push_point(21'($urandom_range(32'h800, 32'hFFFF)) |
                       ((width == SEQ_FOUR) ? 21'h10000 : 21'h0), width);
            if (width == SEQ_TWO) begin
               stream_q[start].data_byte = 8'hC2 | (stream_q[start].data_byte & 8'h1F);
            end
            pick = start + $urandom_range(1, int'(width) - 1);
            stream_q[pick].data_byte = ($urandom_range(0, 1) == 0)
                                     ? 8'($urandom_range(0, 8'h7F))
                                     : 8'($urandom_range(8'hC0, 8'hFF));
         end
         // sequence cut short
         default: begin
            if ($urandom_range(0, 2) == 0) width = SEQ_TWO;
            push_point(21'($urandom_range(32'h800, 32'hFFFF)) | 21'h10000, width);
            repeat ($urandom_range(1, int'(width) - 1)) void'(stream_q.pop_back());
         end
      endcase
   endfunction

   // close the stream, sometimes with an empty last word
   function automatic void close_stream(bit empty_end);
      if (empty_end || stream_q.size() == 0) push_empty();
      stream_q[stream_q.size() - 1].last = 1'b1;
   endfunction

   // ---- driving ----

   task automatic send_word(req_type w);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      if (w.has_byte || w.last) sent_words++;
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_word(stream_q[i]);
      stream_q.delete();
   endtask

   initial begin
      bit faulty;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      req_quiet  = 1'b0;
      rsp_quiet  = 1'b0;
      sent_words = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // ascii extremes, the smallest two-byte value and the largest three- and four-byte values, ended by an empty word
      push_word(8'h00, 1'b1); push_word(8'h7F, 1'b1);
      push_word(8'hC2, 1'b1); push_word(8'h80, 1'b1);
      push_word(8'hEF, 1'b1); push_word(8'hBF, 1'b1); push_word(8'hBF, 1'b1);
      push_point(CODE_MAX, SEQ_FOUR);
      close_stream(1'b1);
      send_stream();
      // empty word without last does nothing, then a lead above f4
      push_empty(); push_word(8'hF5, 1'b1);
      close_stream(1'b0);
      send_stream();
      // bad continuation held at its own offset, next byte only counted
      push_word(8'hE2, 1'b1); push_word(8'h41, 1'b1); push_word(8'h80, 1'b1);
      close_stream(1'b0);
      send_stream();
      // stream ends inside a sequence with a bad byte pending: lead is blamed
      push_word(8'hF0, 1'b1); push_word(8'h41, 1'b1);
      close_stream(1'b0);
      send_stream();
      // surrogate
      push_point(SURR_LO, SEQ_THREE);
      close_stream(1'b0);
      send_stream();
      // above the last code point, after one good byte
      push_word(8'h41, 1'b1); push_point(CODE_MAX + 21'd1, SEQ_FOUR);
      close_stream(1'b0);
      send_stream();
      // c0 lead, then bytes after the first error are ignored
      push_word(8'hC0, 1'b1); push_word(8'hFF, 1'b1);
      close_stream(1'b0);
      send_stream();

      // random streams: mostly well formed, some with one or more faults
      sent_words = 0;
      while (sent_words < RANDOM_WORDS) begin
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         faulty    = ($urandom_range(0, 9) < 4);
         repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 15) == 0) push_empty();
            if (faulty && $urandom_range(0, 99) < 30) push_fault();
            else push_clean();
         end
         close_stream($urandom_range(0, 3) == 0);
         send_stream();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: the watchdog covers a verdict that never comes
      while (verdict_model.verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (verdict_model.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
